[hdl/mvp_pkg.sv]
// -----------------------------------------------------------------------------
// mvp_pkg: shared types and constants for the matrix-vector projection core
// Field widths of the word channels, accumulator width and the control bundle
// that the core hands to each row cell.
// -----------------------------------------------------------------------------
package mvp_pkg;

  // Default matrix size and reset length
  localparam int DIM_DEF      = 8;
  localparam int DIM_USED_RST = 8;

  // Word field widths
  localparam int OP_W    = 1;
  localparam int ADDR_W  = 6;
  localparam int VAL_W   = 16;
  localparam int ROW_W   = 3;
  localparam int PROJ_W  = 23;
  localparam int CFG_W   = 4;

  // Arithmetic widths
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 38;
  localparam int FRAC_W  = 15;

  // Operation codes
  localparam logic [OP_W-1:0] OP_COEFF = 1'b0;
  localparam logic [OP_W-1:0] OP_ELEM  = 1'b1;

  // Per-cycle control shared by all row cells
  typedef struct packed {
    logic wr_en;   // write one coefficient
    logic rd_en;   // fetch coefficient of the current column
    logic mul_en;  // advance the product register
    logic acc_en;  // add product into the row sum
    logic load;    // close the vector: move the sum to the output bank
    logic shift;   // output bank moves one cell toward row 0
    logic clear;   // drop the partial vector
  } mvp_ctrl_t;

endpackage

[hdl/mvp_if.sv]
// -----------------------------------------------------------------------------
// mvp_if: word channels of the matrix-vector projection core
// Input channel carries coefficient writes and vector elements, output channel
// carries one projected component per word.
// -----------------------------------------------------------------------------
interface mvp_in_if;
  import mvp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        coeff_index;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, op, coeff_index, value, input ready);
  modport sink   (input valid, op, coeff_index, value, output ready);
endinterface

interface mvp_out_if;
  import mvp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row;
  logic signed [PROJ_W-1:0] projected;
  logic                     last;

  modport source (output valid, row, projected, last, input ready);
  modport sink   (input valid, row, projected, last, output ready);
endinterface

[hdl/matrix_vector_projection_core.sv]
// -----------------------------------------------------------------------------
// matrix_vector_projection_core: square matrix times streamed vector
// Coefficient writes and vector elements arrive on one word channel; after
// dim_used elements the core emits one projected component for each used row.
//
//   channel   dir  words                          handshake
//   in_ch     in   op, coeff_index, value         valid/ready
//   out_ch    out  row, projected, last           valid/ready
//   cfg_*     in   dim_used (4 bits)              write enable, no read-back
//
// One input word per cycle while in_ch.ready is high; an element passes fetch,
// multiply and accumulate stages in the row cells, which all work on it at once.
// A finished vector drains from a separate output bank, one row per cycle when
// out_ch.ready is high, while the next vector accumulates; input stalls only
// when a vector closes while the bank still holds the previous one.
// Reset clears control and row sums; coefficient contents stay undefined.
// -----------------------------------------------------------------------------
module matrix_vector_projection_core #(
  parameter int DIM = mvp_pkg::DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mvp_in_if.sink                       in_ch,
  mvp_out_if.source                    out_ch,
  input  logic                         cfg_wr_en,
  input  logic [mvp_pkg::CFG_W-1:0]    cfg_wr_data
);
  import mvp_pkg::*;

  localparam int CW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int NMAX   = (DIM < 15) ? DIM : 15;
  localparam int NW     = $clog2(NMAX + 1);
  localparam int RST_N  = (DIM_USED_RST < NMAX) ? DIM_USED_RST : NMAX;

  logic [NW-1:0]            n_r, n_nxt;
  logic [NW-1:0]            count_r, count_nxt;
  logic signed [VAL_W-1:0]  elem_a_r;
  logic                     vld_a_r, last_a_r;
  logic                     vld_b_r, last_b_r;
  logic                     busy_r;
  logic [NW-1:0]            left_r;
  logic [NW-1:0]            row_r;
  logic                     stall;
  logic                     in_acc;
  logic                     out_acc;
  logic                     elem_acc;
  logic                     close_vec;
  mvp_ctrl_t                ctl;
  logic signed [PROJ_W-1:0] bank_w [DIM+1];

  // Hold input while a closing vector waits for the output bank
  assign stall        = vld_b_r && last_b_r && busy_r;
  assign in_ch.ready  = !stall;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign elem_acc     = in_acc && (in_ch.op == OP_ELEM);
  assign close_vec    = (count_r + NW'(1)) == n_r;

  // Clamp the vector length
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      n_nxt = NW'(1);
    end else if (cfg_wr_data > CFG_W'(NMAX)) begin
      n_nxt = NW'(NMAX);
    end else begin
      n_nxt = NW'(cfg_wr_data);
    end
  end

  // Advance the element count
  always_comb begin
    count_nxt = count_r;
    priority if (cfg_wr_en) begin
      count_nxt = '0;
    end else if (elem_acc) begin
      count_nxt = close_vec ? '0 : count_r + NW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Control to the row cells
  always_comb begin
    ctl.wr_en  = in_acc && (in_ch.op == OP_COEFF);
    ctl.rd_en  = elem_acc;
    ctl.mul_en = vld_a_r && !stall;
    ctl.acc_en = vld_b_r && !stall;
    ctl.load   = vld_b_r && last_b_r && !stall;
    ctl.shift  = out_acc;
    ctl.clear  = cfg_wr_en;
  end

  // Element pipeline and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= NW'(RST_N);
      count_r  <= '0;
      vld_a_r  <= 1'b0;
      last_a_r <= 1'b0;
      vld_b_r  <= 1'b0;
      last_b_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n_r <= n_nxt;
      end
      count_r <= count_nxt;
      if (!stall) begin
        vld_a_r  <= elem_acc;
        last_a_r <= close_vec;
        vld_b_r  <= vld_a_r;
        last_b_r <= last_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (elem_acc) begin
      elem_a_r <= in_ch.value;
    end
  end

  // Output bank drain counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
      row_r  <= '0;
    end else begin
      priority if (ctl.load) begin
        busy_r <= 1'b1;
        left_r <= n_r;
        row_r  <= '0;
      end else if (out_acc) begin
        left_r <= left_r - NW'(1);
        row_r  <= row_r + NW'(1);
        if (left_r == NW'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        busy_r <= busy_r;
        left_r <= left_r;
        row_r  <= row_r;
      end
    end
  end

  // Chain of row cells; the bank shifts from the last row toward row 0
  assign bank_w[DIM] = '0;

  for (genvar r = 0; r < DIM; r++) begin : g_cell
    mvp_cell #(
      .DIM (DIM),
      .ROW (r)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .coeff_index (in_ch.coeff_index),
      .coeff_value (in_ch.value),
      .col         (CW'(count_r)),
      .elem        (elem_a_r),
      .bank_in     (bank_w[r+1]),
      .bank_out    (bank_w[r])
    );
  end

  // Result word
  assign out_ch.valid     = busy_r;
  assign out_ch.row       = ROW_W'(row_r);
  assign out_ch.projected = bank_w[0];
  assign out_ch.last      = (left_r == NW'(1));

  // Checks
  a_load_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !busy_r)
    else $error("output bank loaded while still draining");

  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != '0))
    else $error("output bank busy with no words left");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < n_r)
    else $error("element count beyond vector length");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> !busy_r)
    else $error("bank still busy after last word");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (busy_r && vld_b_r && last_b_r))
    else $error("input held without a waiting vector");

endmodule

[hdl/mvp_cell.sv]
// -----------------------------------------------------------------------------
// mvp_cell: one row of the projection chain
// Holds the coefficients of its row, multiplies the broadcast element by the
// coefficient of the current column, keeps the row sum and one output bank
// register that shifts toward row 0 while results drain.
// -----------------------------------------------------------------------------
module mvp_cell #(
  parameter int  DIM = mvp_pkg::DIM_DEF,
  parameter int  ROW = 0,
  localparam int CW  = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mvp_pkg::mvp_ctrl_t               ctl,
  input  logic [mvp_pkg::ADDR_W-1:0]       coeff_index,
  input  logic signed [mvp_pkg::VAL_W-1:0] coeff_value,
  input  logic [CW-1:0]                    col,
  input  logic signed [mvp_pkg::VAL_W-1:0] elem,
  input  logic signed [mvp_pkg::PROJ_W-1:0] bank_in,
  output logic signed [mvp_pkg::PROJ_W-1:0] bank_out
);
  import mvp_pkg::*;

  localparam int AW   = $clog2(DIM * DIM + 64) + 1;
  localparam int BASE = ROW * DIM;

  logic signed [VAL_W-1:0]  mem [DIM];
  logic signed [VAL_W-1:0]  coeff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROJ_W-1:0] bank_r;
  logic [AW-1:0]            addr_ext;
  logic [AW-1:0]            addr_off;
  logic                     wr_hit;
  logic signed [ACC_W-1:0]  acc_sum;

  // Decode whether the write address falls inside this row
  assign addr_ext = AW'(coeff_index);
  assign addr_off = addr_ext - AW'(BASE);
  assign wr_hit   = ctl.wr_en && (addr_ext >= AW'(BASE)) && (addr_ext < AW'(BASE + DIM));

  // Coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[addr_off[CW-1:0]] <= coeff_value;
    end
    if (ctl.rd_en) begin
      coeff_r <= mem[col];
    end
  end

  // Register the product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coeff_r * elem;
    end
  end

  // Row sum; closing a vector leaves it at zero
  assign acc_sum = acc_r + ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctl.clear || ctl.load) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_sum;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Output bank: load the shifted sum, or take the neighbor's word
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      bank_r <= acc_sum[ACC_W-1:FRAC_W];
    end else if (ctl.shift) begin
      bank_r <= bank_in;
    end else begin
      bank_r <= bank_r;
    end
  end

  assign bank_out = bank_r;

endmodule
